### rtl/text_stream_statistics_assert.svh
// Assertion macros shared by the text stream statistics RTL.
`ifndef TEXT_STREAM_STATISTICS_ASSERT_SVH
`define TEXT_STREAM_STATISTICS_ASSERT_SVH
`ifndef SYNTHESIS
`define TSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TSS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSS_ASSERT(lbl, prop, msg)
`define TSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/tss_pkg.sv
// Types, constants and helper functions of the text stream statistics block.
`default_nettype none
package tss_pkg;
	localparam int COUNT_W  = 32;
	localparam int BIN_NUM  = 128;
	localparam int BIN_AW   = $clog2(BIN_NUM);
	localparam int BYTE_W   = 8;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 4 * COUNT_W;

	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
	localparam logic [BYTE_W-1:0] TAB_BYTE     = 8'd9;
	localparam logic [BYTE_W-1:0] CR_BYTE      = 8'd13;
	localparam logic [BYTE_W-1:0] SPACE_BYTE   = 8'd32;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [BIN_AW-1:0]  bin_addr_t;

	typedef struct packed {
		logic      rd_en;
		bin_addr_t addr;
		logic      upd;
	} hist_req_t;

	typedef struct packed {
		logic en;
		logic newline;
		logic blank;
	} tot_upd_t;

	function automatic count_t sat_inc(input count_t v);
		count_t r;
		r = (&v) ? v : v + count_t'(1);
		return r;
	endfunction

	function automatic logic is_blank(input logic [BYTE_W-1:0] b);
		logic r;
		r = ((b >= TAB_BYTE) && (b <= CR_BYTE)) || (b == SPACE_BYTE);
		return r;
	endfunction
endpackage
`default_nettype wire

### rtl/tss_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module tss_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

### rtl/tss_hist.sv
// Histogram bin store with valid flags, read-modify-write and write forwarding.
`default_nettype none
module tss_hist (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tss_pkg::hist_req_t req,
	output tss_pkg::count_t         old_cnt,
	output tss_pkg::count_t         new_cnt
);
	import tss_pkg::*;

	logic [BIN_NUM-1:0] bin_vld_q;
	bin_addr_t          addr_s1;
	logic               vld_s1;
	logic               fwd_s1;
	count_t             fwd_val_s1;
	count_t             rd_data;

	tss_ram #(
		.DEPTH(BIN_NUM),
		.WIDTH(COUNT_W)
	) u_ram (
		.clk    (clk),
		.rd_en  (req.rd_en),
		.rd_addr(req.addr),
		.rd_data(rd_data),
		.wr_en  (req.upd),
		.wr_addr(addr_s1),
		.wr_data(new_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
		end else if (req.upd) begin
			bin_vld_q[addr_s1] <= 1'b1;
		end
	end

	// The write of the item ahead lands on the same edge as this read.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			addr_s1    <= req.addr;
			vld_s1     <= bin_vld_q[req.addr];
			fwd_s1     <= req.upd && (addr_s1 == req.addr);
			fwd_val_s1 <= new_cnt;
		end
	end

	assign old_cnt = fwd_s1 ? fwd_val_s1 : (vld_s1 ? rd_data : '0);
	assign new_cnt = sat_inc(old_cnt);
endmodule
`default_nettype wire

### rtl/tss_totals.sv
// Saturating character, line and word totals with the in-word flag.
`default_nettype none
module tss_totals (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tss_pkg::tot_upd_t upd,
	output tss_pkg::count_t        chars_nxt,
	output tss_pkg::count_t        lines_nxt,
	output tss_pkg::count_t        words_nxt
);
	import tss_pkg::*;

	count_t chars_q;
	count_t lines_q;
	count_t words_q;
	logic   in_word_q;

	always_comb begin
		chars_nxt = chars_q;
		lines_nxt = lines_q;
		words_nxt = words_q;
		if (upd.en) begin
			chars_nxt = sat_inc(chars_q);
			if (upd.newline) begin
				lines_nxt = sat_inc(lines_q);
			end
			if (!upd.blank && !in_word_q) begin
				words_nxt = sat_inc(words_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q   <= '0;
			lines_q   <= '0;
			words_q   <= '0;
			in_word_q <= 1'b0;
		end else begin
			chars_q <= chars_nxt;
			lines_q <= lines_nxt;
			words_q <= words_nxt;
			if (upd.en) begin
				in_word_q <= !upd.blank;
			end
		end
	end
endmodule
`default_nettype wire

### rtl/text_stream_statistics.sv
// Top level of the text stream statistics block.
`default_nettype none
`include "text_stream_statistics_assert.svh"
// Counts characters, newline lines and words of a byte stream and keeps a
// histogram of the byte values 0 to 127; a request of the read kind returns
// one histogram bin together with the running totals. Every request yields
// exactly one response; a new request is taken in every cycle unless the output
// stalls. A request moves through stage one into the output register: the
// histogram memory is read on acceptance, and the bin is incremented and written
// back as the request leaves stage one, with the count of the request just ahead
// forwarded when both hit the same bin. Histogram bins read as zero after
// reset through per-bin valid flags, so the block is ready at once with no
// clearing pass. All counts saturate at their largest value.
module text_stream_statistics (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// byte_value [7:0], bin_index [14:8], zero [15]
	input  wire logic [tss_pkg::S_DATA_W-1:0]   s_axis_tdata,
	// kind
	input  wire logic                           s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// char_total [31:0], line_total [63:32], word_total [95:64], bin_count [127:96]
	output logic      [tss_pkg::M_DATA_W-1:0]   m_axis_tdata,
	// bin_valid
	output logic                                m_axis_tuser
);
	import tss_pkg::*;

	logic              accept;
	logic              advance;
	logic              s1_go;
	logic              s1_valid_q;
	logic              kind_s1;
	logic [BYTE_W-1:0] byte_s1;
	hist_req_t         hist_req;
	tot_upd_t          tot_upd;
	count_t            old_cnt;
	count_t            new_cnt;
	count_t            chars_nxt;
	count_t            lines_nxt;
	count_t            words_nxt;
	count_t            bin_cnt;
	logic              bin_vld;
	logic              m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;
	logic              m_user_q;

	assign advance       = !m_valid_q || m_axis_tready;
	assign s1_go         = s1_valid_q && advance;
	assign s_axis_tready = !s1_valid_q || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign hist_req.rd_en = accept;
	assign hist_req.addr  = (s_axis_tuser == KIND_READ) ? s_axis_tdata[BYTE_W +: BIN_AW]
	                                                    : s_axis_tdata[BIN_AW-1:0];
	assign hist_req.upd   = s1_go && (kind_s1 == KIND_TEXT) && !byte_s1[BYTE_W-1];

	assign tot_upd.en      = s1_go && (kind_s1 == KIND_TEXT);
	assign tot_upd.newline = (byte_s1 == NEWLINE_BYTE);
	assign tot_upd.blank   = is_blank(byte_s1);

	tss_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hist_req),
		.old_cnt(old_cnt),
		.new_cnt(new_cnt)
	);

	tss_totals u_totals (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (tot_upd),
		.chars_nxt(chars_nxt),
		.lines_nxt(lines_nxt),
		.words_nxt(words_nxt)
	);

	always_comb begin
		bin_vld = (kind_s1 == KIND_READ) || !byte_s1[BYTE_W-1];
		if (kind_s1 == KIND_READ) begin
			bin_cnt = old_cnt;
		end else if (bin_vld) begin
			bin_cnt = new_cnt;
		end else begin
			bin_cnt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				s1_valid_q <= s_axis_tvalid;
			end
			if (advance) begin
				m_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= s_axis_tuser;
			byte_s1 <= s_axis_tdata[BYTE_W-1:0];
		end
		if (s1_go) begin
			m_data_q <= {bin_cnt, words_nxt, lines_nxt, chars_nxt};
			m_user_q <= bin_vld;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	`TSS_ASSERT(a_accept_fills_s1, accept |=> s1_valid_q, "Accepted request did not reach stage one.")
	`TSS_ASSERT(a_read_bin_valid, (s1_go && (kind_s1 == KIND_READ)) |=> m_axis_tuser, "Read response without a valid bin.")
	`TSS_ASSERT(a_words_le_chars, m_axis_tvalid |-> (m_axis_tdata[3*COUNT_W-1:2*COUNT_W] <= m_axis_tdata[COUNT_W-1:0]), "Word total exceeds character total.")
	`TSS_ASSERT(a_s1_hold, (s1_valid_q && !advance) |=> (s1_valid_q && $stable(byte_s1) && $stable(kind_s1)), "Stalled stage one request changed.")
	`TSS_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!s1_valid_q && !m_axis_tvalid), "Pipeline not empty during reset.")
endmodule
`default_nettype wire
